[design/adms_pkg.sv]
package adms_pkg;

  // Field widths of the request and response payloads
  localparam int unsigned VertexW = 4;
  localparam int unsigned VisitW  = 5;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_DEL   = 2'd1,
    FUNC_MARK  = 2'd2,
    FUNC_TRAV  = 2'd3
  } func_e;

  typedef struct packed {
    func_e                func;
    logic [VertexW-1:0]   src_vertex;
    logic [VertexW-1:0]   dst_vertex;
  } req_t;

  typedef struct packed {
    logic [VertexW-1:0]   visited_vertex;
    logic [VisitW-1:0]    visit_number;
    logic                 last;
    logic                 graph_nonempty;
  } rsp_t;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RMW  = 5'b00010,
    ST_ACK  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_POP  = 5'b10000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // latch request, read adjacency row of src
    logic mark_vertex; // set src present
    logic write_row;   // write back modified adjacency row
    logic start_walk;  // push start vertex, init visited and counters
    logic push;        // visit lowest unvisited neighbor
    logic pop_read;    // drop top, read parent from stack
    logic pop_load;    // read adjacency row of parent
    logic ack;         // emit acknowledge response
    logic finish;      // emit final visit response
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic found;       // top vertex has an unvisited neighbor
    logic depth_one;   // only the start vertex is on the stack
  } sts_t;

endpackage

[design/adjacency_matrix_dfs_core.sv]
// Directed graph store with depth-first walk.
// Request channel: req_i is taken at a rising edge with start high and busy
// low. func selects add arc, delete arc, mark vertex or walk from src_vertex.
// Response channel: each response sits on rsp_o for one cycle with
// rsp_valid_o high; there is no backpressure, the receiver must take it.
// Add and delete read the adjacency row of src, write it back modified
// and then acknowledge; mark and out-of-range requests acknowledge with
// no row write. A walk pushes each non-start vertex from a scan step, and
// each stack pop does a stack read, then an adjacency row read; V visited
// vertices need V-1 pops. Visits leave one step late so the final one can
// carry last; busy drops as that last response is registered, so the next
// request may be taken while it is on the ports.
// Reset clears the vertex mask, stack depth, controller and the per-row
// valid bits of the adjacency memory, so every row reads as empty with no
// clearing pass; a request may be taken in the first cycle after reset.
module adjacency_matrix_dfs_core import adms_pkg::*; #(
  parameter int unsigned NODES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  cmd_t cmd;
  sts_t sts;

  adms_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  adms_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // Every accepted request takes the controller out of idle, so busy goes high
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  // The final response of a request shows only once the block is idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.last |-> !busy)
    else $error("last response while still busy");

  // A non-final response is always a walk visit, with the walk still running
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.last |-> busy && (rsp_o.visit_number != '0))
    else $error("intermediate response outside a walk");

  // Only the controller can raise a response; ack, push, finish and pop_read never coincide
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.ack, cmd.push, cmd.finish, cmd.pop_read}) <= 1)
    else $error("conflicting controller commands");

endmodule

[design/adms_ram.sv]
module adms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/adms_ctrl.sv]
module adms_ctrl import adms_pkg::*; #(
  parameter int unsigned NODES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy
);

  state_e state_q, state_d;
  logic   src_ok, dst_ok;

  // Vertex range checks for NODES below 16
  assign src_ok = 32'(req_i.src_vertex) < NODES;
  assign dst_ok = 32'(req_i.dst_vertex) < NODES;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          case (req_i.func)
            FUNC_ADD, FUNC_DEL: begin
              state_d = (src_ok && dst_ok) ? ST_RMW : ST_ACK;
            end
            FUNC_MARK: begin
              cmd_o.mark_vertex = src_ok;
              state_d           = ST_ACK;
            end
            FUNC_TRAV: begin
              cmd_o.start_walk = src_ok;
              state_d          = src_ok ? ST_SCAN : ST_ACK;
            end
            default: state_d = ST_ACK;
          endcase
        end
      end
      ST_RMW: begin
        cmd_o.write_row = 1'b1;
        state_d         = ST_ACK;
      end
      ST_ACK: begin
        cmd_o.ack = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts_i.found) begin
          cmd_o.push = 1'b1;
        end else if (sts_i.depth_one) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.pop_read = 1'b1;
          state_d        = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

[design/adms_datapath.sv]
module adms_datapath import adms_pkg::*; #(
  parameter int unsigned NODES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned DW = $clog2(NODES + 1);

  // Lowest set bit index
  function automatic logic [AW-1:0] low_idx(input logic [NODES-1:0] v);
    logic [AW-1:0] r;
    r = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (v[i]) r = AW'(i);
    end
    return r;
  endfunction

  function automatic logic [NODES-1:0] bit_of(input logic [AW-1:0] idx);
    return {{(NODES-1){1'b0}}, 1'b1} << idx;
  endfunction

  req_t              req_q;
  logic [NODES-1:0]  present_q, present_d;
  logic [NODES-1:0]  row_valid_q;
  logic              rdv_q;
  logic [NODES-1:0]  visited_q;
  logic [DW-1:0]     depth_q;
  logic [AW-1:0]     pend_q;
  logic [VisitW-1:0] count_q;
  logic              rsp_valid_q;
  rsp_t              rsp_q, rsp_d;

  logic [NODES-1:0]  adj_rdata, adj_row, adj_wdata, cand;
  logic [AW-1:0]     adj_raddr, adj_waddr, found_idx;
  logic [AW-1:0]     stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic [AW-1:0]     in_src, q_src, q_dst;
  logic              stk_we;
  logic [DW-1:0]     depth_m2;

  assign in_src = AW'(req_i.src_vertex);
  assign q_src  = AW'(req_q.src_vertex);
  assign q_dst  = AW'(req_q.dst_vertex);

  // Rows never written read as empty
  assign adj_row   = rdv_q ? adj_rdata : '0;
  assign cand      = adj_row & ~visited_q;
  assign found_idx = low_idx(cand);

  assign sts_o.found     = |cand;
  assign sts_o.depth_one = (depth_q == DW'(1));

  // Adjacency read address select
  always_comb begin
    if (cmd_i.accept) begin
      adj_raddr = in_src;
    end else if (cmd_i.pop_load) begin
      adj_raddr = stk_rdata;
    end else begin
      adj_raddr = found_idx;
    end
  end

  // Read-modify-write of one row for add and delete
  assign adj_waddr = q_src;
  assign adj_wdata = (req_q.func == FUNC_ADD) ? (adj_row | bit_of(q_dst))
                                              : (adj_row & ~bit_of(q_dst));

  adms_ram #(
    .Width (NODES),
    .Depth (NODES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_row),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  // Walk stack holds vertices only; the next neighbor is the lowest
  // unvisited one, so no scan position needs to be kept
  assign depth_m2  = depth_q - DW'(2);
  assign stk_we    = cmd_i.start_walk | cmd_i.push;
  assign stk_waddr = cmd_i.start_walk ? '0 : depth_q[AW-1:0];
  assign stk_wdata = cmd_i.start_walk ? in_src : found_idx;
  assign stk_raddr = depth_m2[AW-1:0];

  adms_ram #(
    .Width (AW),
    .Depth (NODES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Present mask update
  always_comb begin
    present_d = present_q;
    if (cmd_i.mark_vertex) begin
      present_d = present_q | bit_of(in_src);
    end else if (cmd_i.write_row && (req_q.func == FUNC_ADD)) begin
      present_d = present_q | bit_of(q_src) | bit_of(q_dst);
    end
  end

  // Response build: a visit is held back one step so that last is known
  always_comb begin
    rsp_d = rsp_q;
    rsp_d.graph_nonempty = |present_q;
    if (cmd_i.ack) begin
      rsp_d.visited_vertex = '0;
      rsp_d.visit_number   = '0;
      rsp_d.last           = 1'b1;
    end else begin
      rsp_d.visited_vertex = VertexW'(pend_q);
      rsp_d.visit_number   = count_q;
      rsp_d.last           = cmd_i.finish;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      row_valid_q <= '0;
      rdv_q       <= 1'b0;
      visited_q   <= '0;
      depth_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      present_q   <= present_d;
      rdv_q       <= row_valid_q[adj_raddr];
      rsp_valid_q <= cmd_i.ack | cmd_i.push | cmd_i.finish;
      if (cmd_i.write_row) begin
        row_valid_q[adj_waddr] <= 1'b1;
      end
      if (cmd_i.start_walk) begin
        visited_q <= bit_of(in_src);
        depth_q   <= DW'(1);
      end else if (cmd_i.push) begin
        visited_q <= visited_q | bit_of(found_idx);
        depth_q   <= depth_q + DW'(1);
      end else if (cmd_i.pop_read || cmd_i.finish) begin
        depth_q   <= depth_q - DW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
    if (cmd_i.start_walk) begin
      pend_q  <= in_src;
      count_q <= VisitW'(1);
    end else if (cmd_i.push) begin
      pend_q  <= found_idx;
      count_q <= count_q + VisitW'(1);
    end
    if (cmd_i.ack || cmd_i.push || cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[verif/adjacency_matrix_dfs_core_tb.sv]
`timescale 1ns / 100ps

module adjacency_matrix_dfs_core_tb;
  import adms_pkg::*;

  localparam int unsigned NODES         = 16;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 3 * NODES + 16;
  localparam int unsigned RANDOM_ITEMS  = 330;

  // Graph mirror and the queue of responses it predicts
  class dfs_scoreboard;
    logic [NODES-1:0] adj [NODES];
    logic [NODES-1:0] present;
    rsp_t             expected_q [$];
    int unsigned      errors;
    int unsigned      n_req;
    int unsigned      n_rsp;
    int unsigned      n_walks;
    int unsigned      longest_walk;

    function new();
      foreach (adj[i]) adj[i] = '0;
      present      = '0;
      errors       = 0;
      n_req        = 0;
      n_rsp        = 0;
      n_walks      = 0;
      longest_walk = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push_expect(int unsigned vtx, int unsigned num, bit is_last);
      rsp_t r;
      r.visited_vertex = vtx[VertexW-1:0];
      r.visit_number   = num[VisitW-1:0];
      r.last           = is_last;
      r.graph_nonempty = (present != '0);
      expected_q.push_back(r);
    endfunction

    // Depth-first walk, neighbors in ascending order, explicit stack
    function void predict_walk(int unsigned root);
      logic [NODES-1:0] seen;
      int unsigned      stk_vtx [NODES];
      int unsigned      stk_next [NODES];
      int unsigned      order [NODES];
      int unsigned      depth;
      int unsigned      count;
      int unsigned      v;
      int unsigned      w;
      bit               found;
      seen       = '0;
      seen[root] = 1'b1;
      order[0]   = root;
      count      = 1;
      stk_vtx[0] = root;
      stk_next[0] = 0;
      depth      = 1;
      while (depth > 0) begin
        v     = stk_vtx[depth-1];
        w     = stk_next[depth-1];
        found = 1'b0;
        while (w < NODES && !found) begin
          if (adj[v][w] && !seen[w]) found = 1'b1;
          else w++;
        end
        if (found && depth < NODES && count < 16) begin
          stk_next[depth-1] = w + 1;
          seen[w]           = 1'b1;
          order[count]      = w;
          count++;
          stk_vtx[depth]    = w;
          stk_next[depth]   = 0;
          depth++;
        end else begin
          depth--;
        end
      end
      for (int unsigned i = 0; i < count; i++) push_expect(order[i], i + 1, i == count - 1);
      n_walks++;
      if (count > longest_walk) longest_walk = count;
    endfunction

    function void note_request(req_t r);
      int unsigned s;
      int unsigned d;
      s = r.src_vertex;
      d = r.dst_vertex;
      n_req++;
      if (r.func == FUNC_TRAV && s < NODES) begin
        predict_walk(s);
      end else begin
        case (r.func)
          FUNC_ADD: begin
            if (s < NODES && d < NODES) begin
              present[s] = 1'b1;
              present[d] = 1'b1;
              adj[s][d]  = 1'b1;
            end
          end
          FUNC_DEL: begin
            if (s < NODES && d < NODES) adj[s][d] = 1'b0;
          end
          FUNC_MARK: begin
            if (s < NODES) present[s] = 1'b1;
          end
          default: ;
        endcase
        push_expect(0, 0, 1'b1);
      end
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: response %0d %s mismatch: expected %0d, actual %0d",
                 $time, n_rsp, name, want, got);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      n_rsp++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response: expected none, actual vertex=%0d number=%0d",
                 $time, got.visited_vertex, got.visit_number);
      end else begin
        want = expected_q.pop_front();
        cmp_field("visited_vertex", 8'(want.visited_vertex), 8'(got.visited_vertex));
        cmp_field("visit_number", 8'(want.visit_number), 8'(got.visit_number));
        cmp_field("last", 8'(want.last), 8'(got.last));
        cmp_field("graph_nonempty", 8'(want.graph_nonempty), 8'(got.graph_nonempty));
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic start       = 1'b0;
  req_t req_i       = '0;
  logic busy;
  logic rsp_valid_o;
  rsp_t rsp_o;

  dfs_scoreboard sb = new();
  int unsigned   sent       = 0;
  int unsigned   burst_left = 0;
  int unsigned   cycles     = 0;

  adjacency_matrix_dfs_core #(
    .NODES(NODES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Monitor: responses first, then the request taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o) sb.check_response(rsp_o);
      if (start && !busy) sb.note_request(req_i);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit hit, %0d responses outstanding", $time, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // Present one request, hold until taken, then draw the gap to the next
  task automatic issue(input func_e f, input int unsigned s, input int unsigned d);
    req_t        r;
    int unsigned gap;
    r.func       = f;
    r.src_vertex = s[VertexW-1:0];
    r.dst_vertex = d[VertexW-1:0];
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 20);
      gap = $urandom_range(0, 10);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending until every predicted response is back, then let it settle
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // walks on an empty graph, start not present
    issue(FUNC_TRAV, 0, 15);
    issue(FUNC_TRAV, 15, 0);
    // delete of a missing arc
    issue(FUNC_DEL, 5, 6);
    issue(FUNC_MARK, 15, 10);
    issue(FUNC_ADD, 0, 15);
    issue(FUNC_ADD, 15, 0);
    issue(FUNC_ADD, 7, 7);
    issue(FUNC_ADD, 0, 8);
    issue(FUNC_ADD, 8, 3);
    issue(FUNC_ADD, 15, 3);
    issue(FUNC_TRAV, 0, 5);
    issue(FUNC_TRAV, 7, 15);
    // isolated vertex that was never marked
    issue(FUNC_TRAV, 4, 0);
    issue(FUNC_DEL, 0, 15);
    issue(FUNC_DEL, 0, 15);
    issue(FUNC_TRAV, 15, 9);
    issue(FUNC_MARK, 0, 15);
    issue(FUNC_ADD, 15, 15);
    issue(FUNC_TRAV, 8, 6);
    issue(FUNC_TRAV, 3, 12);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned perm [NODES];
    int unsigned len;
    int unsigned tmp;
    int unsigned j;
    int unsigned i;
    int unsigned s;
    int unsigned d;
    int unsigned pick;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // chain over a random permutation of vertices, walked from its head
        for (i = 0; i < NODES; i++) perm[i] = i;
        for (i = NODES - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        len = ($urandom_range(0, 7) == 0) ? NODES : $urandom_range(3, 8);
        for (i = 0; i + 1 < len; i++) issue(FUNC_ADD, perm[i], perm[i+1]);
        issue(FUNC_TRAV, perm[0], $urandom_range(0, 15));
        if ($urandom_range(0, 1) == 1) begin
          for (i = 0; i + 1 < len; i++) issue(FUNC_DEL, perm[i], perm[i+1]);
        end
      end else if (pick < 55) begin
        issue(FUNC_ADD, $urandom_range(0, 15), $urandom_range(0, 15));
      end else if (pick < 75) begin
        // mostly remove an arc that exists
        s = $urandom_range(0, NODES - 1);
        if (sb.adj[s] != '0 && $urandom_range(0, 3) != 0) begin
          do d = $urandom_range(0, NODES - 1); while (!sb.adj[s][d]);
        end else begin
          d = $urandom_range(0, 15);
        end
        issue(FUNC_DEL, s, d);
      end else if (pick < 80) begin
        issue(FUNC_MARK, $urandom_range(0, 15), $urandom_range(0, 15));
      end else begin
        issue(FUNC_TRAV, $urandom_range(0, 15), $urandom_range(0, 15));
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_drained();
    run_random(sent + RANDOM_ITEMS);
    wait_drained();

    $display("summary: %0d requests, %0d responses checked, %0d walks, longest %0d vertices",
             sb.n_req, sb.n_rsp, sb.n_walks, sb.longest_walk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0t: %0d mismatches, %0d responses never seen", $time, sb.errors,
               sb.pending());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
design/adms_pkg.sv
design/adms_ram.sv
design/adms_ctrl.sv
design/adms_datapath.sv
design/adjacency_matrix_dfs_core.sv
verif/adjacency_matrix_dfs_core_tb.sv
